### hdl/best_fit_heap_allocator_defines.svh
// Assertion macros shared by the heap allocator RTL.
`ifndef BEST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Condition holds at every clock edge outside reset.
`define BFHA_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence holds in the same cycle as the antecedent.
`define BFHA_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence holds in the cycle after the antecedent.
`define BFHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/bfha_pkg.sv
// Types and constants of the best-fit heap allocator.
`timescale 1ns / 1ps
package bfha_pkg;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_MOVE,
      S_SPLIT_WR,
      S_REL_RN,
      S_REL_RP,
      S_REL_MERGE,
      S_DONE
   } state_type;

   // One block table entry
   typedef struct packed {
      logic [31:0] offset;
      logic [31:0] size;
      logic        free;
   } entry_type;

   // Operation codes
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_RESIZE  = 2'd2;

   // Status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_REJECT    = 3'd1;
   localparam logic [2:0] ST_EXHAUSTED = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_UNKNOWN   = 3'd4;

   // Register indexes
   localparam logic CSR_HEAP_LIMIT  = 1'b0;
   localparam logic CSR_SPLIT_SLACK = 1'b1;

   // Register reset values
   localparam logic [31:0] HEAP_LIMIT_RESET  = 32'd1048576;
   localparam logic [15:0] SPLIT_SLACK_RESET = 16'd64;

endpackage

### hdl/best_fit_heap_allocator.sv
// Best-fit heap allocator over an address-ordered block table held in one memory.
// Each item scans the whole table, then is decided; a split shifts the later entries up and
// writes the leftover block, a release reads both neighbours, merges and shifts entries down.
// One item at a time: a new request is taken only in idle, once the last result is registered.
// Reset (synchronous, active high) clears the count, heap end and sequencer and restores
// the registers; table contents are not cleared and are read only below the count.
`timescale 1ns / 1ps
`include "best_fit_heap_allocator_defines.svh"
module best_fit_heap_allocator #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // request_size[31:0], addr_in[63:32]
   input  logic [1:0]  req_tuser,   // op[1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // addr_out[31:0], status[34:32], copy_bytes[66:35]
   // configuration
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [CW-1:0] CMAX  = CW'(MAX_BLOCKS);
   localparam logic [31:0]   HDR32 = 32'(HEADER_BYTES);

   bfha_pkg::state_type state_ff, state_in;

   // request
   logic [1:0]  op_ff, op_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] addr_ff, addr_in;

   // heap state and registers
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   heap_end_ff, heap_end_in;
   logic [31:0]   limit_ff, limit_in;
   logic [15:0]   slack_ff, slack_in;

   // scan
   logic [CW-1:0] sc_rd_ff, sc_rd_in;
   logic          sc_pend_ff, sc_pend_in;
   logic [AW-1:0] sc_tag_ff, sc_tag_in;
   logic          found_ff, found_in;
   logic [AW-1:0] found_idx_ff, found_idx_in;
   logic [31:0]   found_off_ff, found_off_in;
   logic [31:0]   found_size_ff, found_size_in;
   logic          best_ff, best_in;
   logic [AW-1:0] best_idx_ff, best_idx_in;
   logic [31:0]   best_off_ff, best_off_in;
   logic [31:0]   best_size_ff, best_size_in;

   // release
   logic [AW-1:0] rel_idx_ff, rel_idx_in;
   logic          next_free_ff, next_free_in;
   logic [31:0]   acc_ff, acc_in;

   // entry mover
   logic [CW-1:0] mv_rd_ff, mv_rd_in;
   logic [CW-1:0] mv_left_ff, mv_left_in;
   logic          mv_up_ff, mv_up_in;
   logic [1:0]    mv_k_ff, mv_k_in;
   logic          mv_pend_ff, mv_pend_in;
   logic [AW-1:0] mv_tag_ff, mv_tag_in;
   logic          mv_split_ff, mv_split_in;

   // result
   logic [31:0] res_addr_ff, res_addr_in;
   logic [2:0]  res_status_ff, res_status_in;
   logic [31:0] res_copy_ff, res_copy_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [66:0] rsp_data_ff, rsp_data_in;

   // table port
   logic                mem_we;
   logic [AW-1:0]       mem_wa;
   bfha_pkg::entry_type mem_wd;
   logic [AW-1:0]       mem_ra;
   bfha_pkg::entry_type tbl_rdata;

   bfha_table #(
      .DEPTH (MAX_BLOCKS),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (mem_ra),
      .rd_data (tbl_rdata)
   );

   // decision terms
   logic        is_alloc, is_release, is_resize, addr_zero;
   logic        resize_keep, want_alloc, use_best, alloc_split, alloc_ok, go_release;
   logic        scan_done;
   logic [33:0] split_lim, app_need;
   logic [2:0]  alloc_status;

   assign is_alloc    = (op_ff == bfha_pkg::OP_ALLOC);
   assign is_release  = (op_ff == bfha_pkg::OP_RELEASE);
   assign is_resize   = (op_ff == bfha_pkg::OP_RESIZE);
   assign addr_zero   = (addr_ff == 32'd0);
   assign resize_keep = found_ff && (found_size_ff > size_ff);
   assign want_alloc  = is_alloc || (is_resize && !addr_zero && found_ff && !resize_keep);
   assign use_best    = best_ff && (size_ff != 32'd0);
   assign split_lim   = {2'b0, size_ff} + {2'b0, HDR32} + {18'b0, slack_ff};
   assign alloc_split = want_alloc && use_best && ({2'b0, best_size_ff} > split_lim)
                        && (count_ff < CMAX);
   assign app_need    = {2'b0, heap_end_ff} + {2'b0, HDR32} + {2'b0, size_ff};
   assign scan_done   = (sc_rd_ff >= count_ff) && !sc_pend_ff;

   // status of the allocation step
   always_comb begin
      if (size_ff == 32'd0) begin
         alloc_status = bfha_pkg::ST_REJECT;
      end else if (best_ff) begin
         alloc_status = bfha_pkg::ST_OK;
      end else if (count_ff >= CMAX) begin
         alloc_status = bfha_pkg::ST_FULL;
      end else if (app_need > {2'b0, limit_ff}) begin
         alloc_status = bfha_pkg::ST_EXHAUSTED;
      end else begin
         alloc_status = bfha_pkg::ST_OK;
      end
   end

   assign alloc_ok   = (alloc_status == bfha_pkg::ST_OK);
   assign go_release = (is_release && !addr_zero && found_ff)
                       || (is_resize && want_alloc && alloc_ok);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfha_pkg::S_IDLE: begin
            if (req_tvalid) state_in = bfha_pkg::S_SCAN;
         end
         bfha_pkg::S_SCAN: begin
            if (scan_done) state_in = bfha_pkg::S_DECIDE;
         end
         bfha_pkg::S_DECIDE: begin
            if (alloc_split) begin
               state_in = bfha_pkg::S_MOVE;
            end else if (go_release) begin
               state_in = bfha_pkg::S_REL_RN;
            end else begin
               state_in = bfha_pkg::S_DONE;
            end
         end
         bfha_pkg::S_MOVE: begin
            if (mv_left_ff == '0 && !mv_pend_ff) begin
               state_in = mv_split_ff ? bfha_pkg::S_SPLIT_WR : bfha_pkg::S_DONE;
            end
         end
         bfha_pkg::S_SPLIT_WR: begin
            state_in = is_resize ? bfha_pkg::S_REL_RN : bfha_pkg::S_DONE;
         end
         bfha_pkg::S_REL_RN:    state_in = bfha_pkg::S_REL_RP;
         bfha_pkg::S_REL_RP:    state_in = bfha_pkg::S_REL_MERGE;
         bfha_pkg::S_REL_MERGE: state_in = bfha_pkg::S_MOVE;
         bfha_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = bfha_pkg::S_IDLE;
         end
         default: state_in = bfha_pkg::S_IDLE;
      endcase
   end

   // datapath and table accesses
   always_comb begin
      logic          pf;
      logic          nf;
      logic [CW-1:0] p;
      logic [1:0]    k;

      op_in         = op_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      count_in      = count_ff;
      heap_end_in   = heap_end_ff;
      limit_in      = limit_ff;
      slack_in      = slack_ff;
      sc_rd_in      = sc_rd_ff;
      sc_pend_in    = sc_pend_ff;
      sc_tag_in     = sc_tag_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      found_off_in  = found_off_ff;
      found_size_in = found_size_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      best_off_in   = best_off_ff;
      best_size_in  = best_size_ff;
      rel_idx_in    = rel_idx_ff;
      next_free_in  = next_free_ff;
      acc_in        = acc_ff;
      mv_rd_in      = mv_rd_ff;
      mv_left_in    = mv_left_ff;
      mv_up_in      = mv_up_ff;
      mv_k_in       = mv_k_ff;
      mv_pend_in    = mv_pend_ff;
      mv_tag_in     = mv_tag_ff;
      mv_split_in   = mv_split_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      res_copy_in   = res_copy_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_wa        = '0;
      mem_wd        = '0;
      mem_ra        = sc_rd_ff[AW-1:0];
      pf            = 1'b0;
      nf            = 1'b0;
      p             = '0;
      k             = 2'd0;

      // configuration writes
      if (csr_we) begin
         if (csr_index == bfha_pkg::CSR_HEAP_LIMIT) begin
            limit_in = csr_wdata;
         end else begin
            slack_in = csr_wdata[15:0];
         end
      end

      // response handshake
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      case (state_ff)
         bfha_pkg::S_IDLE: begin
            if (req_tvalid) begin
               op_in      = req_tuser;
               size_in    = req_tdata[31:0];
               addr_in    = req_tdata[63:32];
               sc_rd_in   = '0;
               sc_pend_in = 1'b0;
               found_in   = 1'b0;
               best_in    = 1'b0;
            end
         end

         // one read per cycle, compare the entry returned from the previous read
         bfha_pkg::S_SCAN: begin
            if (sc_rd_ff < count_ff) begin
               mem_ra     = sc_rd_ff[AW-1:0];
               sc_rd_in   = sc_rd_ff + 1'b1;
               sc_pend_in = 1'b1;
               sc_tag_in  = sc_rd_ff[AW-1:0];
            end else begin
               sc_pend_in = 1'b0;
            end
            if (sc_pend_ff) begin
               if (!found_ff && !tbl_rdata.free
                   && ({1'b0, tbl_rdata.offset} + {1'b0, HDR32}) == {1'b0, addr_ff}) begin
                  found_in      = 1'b1;
                  found_idx_in  = sc_tag_ff;
                  found_off_in  = tbl_rdata.offset;
                  found_size_in = tbl_rdata.size;
               end
               if (tbl_rdata.free && tbl_rdata.size >= size_ff
                   && (!best_ff || tbl_rdata.size < best_size_ff)) begin
                  best_in      = 1'b1;
                  best_idx_in  = sc_tag_ff;
                  best_off_in  = tbl_rdata.offset;
                  best_size_in = tbl_rdata.size;
               end
            end
         end

         bfha_pkg::S_DECIDE: begin
            res_addr_in   = 32'd0;
            res_status_in = bfha_pkg::ST_OK;
            res_copy_in   = 32'd0;
            rel_idx_in    = found_idx_ff;
            if (is_release) begin
               if (!addr_zero && !found_ff) res_status_in = bfha_pkg::ST_UNKNOWN;
            end else if (is_resize) begin
               if (addr_zero) begin
                  res_status_in = bfha_pkg::ST_REJECT;
               end else if (!found_ff) begin
                  res_status_in = bfha_pkg::ST_UNKNOWN;
               end else if (resize_keep) begin
                  res_addr_in = addr_ff;
               end
            end else if (!is_alloc) begin
               res_status_in = bfha_pkg::ST_REJECT;
            end
            // allocation step
            if (want_alloc) begin
               res_status_in = alloc_status;
               if (alloc_ok) begin
                  res_copy_in = is_resize ? found_size_ff : 32'd0;
                  if (use_best) begin
                     res_addr_in = best_off_ff + HDR32;
                     mem_we      = 1'b1;
                     mem_wa      = best_idx_ff;
                     mem_wd      = '{offset: best_off_ff,
                                     size:   alloc_split ? size_ff : best_size_ff,
                                     free:   1'b0};
                     if (alloc_split) begin
                        count_in    = count_ff + 1'b1;
                        mv_up_in    = 1'b1;
                        mv_split_in = 1'b1;
                        mv_k_in     = 2'd1;
                        mv_pend_in  = 1'b0;
                        mv_rd_in    = count_ff - 1'b1;
                        mv_left_in  = count_ff - CW'(best_idx_ff) - 1'b1;
                        if (found_idx_ff > best_idx_ff) rel_idx_in = found_idx_ff + 1'b1;
                     end
                  end else begin
                     res_addr_in = heap_end_ff + HDR32;
                     mem_we      = 1'b1;
                     mem_wa      = count_ff[AW-1:0];
                     mem_wd      = '{offset: heap_end_ff, size: size_ff, free: 1'b0};
                     count_in    = count_ff + 1'b1;
                     heap_end_in = app_need[31:0];
                  end
               end
            end
         end

         // shift entries up or down, read one and write the previous one each cycle
         bfha_pkg::S_MOVE: begin
            if (mv_left_ff != '0) begin
               mem_ra     = mv_rd_ff[AW-1:0];
               mv_rd_in   = mv_up_ff ? mv_rd_ff - 1'b1 : mv_rd_ff + 1'b1;
               mv_left_in = mv_left_ff - 1'b1;
               mv_pend_in = 1'b1;
               mv_tag_in  = mv_rd_ff[AW-1:0];
            end else begin
               mv_pend_in = 1'b0;
            end
            if (mv_pend_ff) begin
               mem_we = 1'b1;
               mem_wa = mv_up_ff ? mv_tag_ff + 1'b1 : mv_tag_ff - AW'(mv_k_ff);
               mem_wd = tbl_rdata;
            end
         end

         // leftover of a split block becomes a free entry after the reused one
         bfha_pkg::S_SPLIT_WR: begin
            mem_we = 1'b1;
            mem_wa = best_idx_ff + 1'b1;
            mem_wd = '{offset: best_off_ff + HDR32 + size_ff,
                       size:   best_size_ff - size_ff - HDR32,
                       free:   1'b1};
         end

         bfha_pkg::S_REL_RN: begin
            mem_ra = rel_idx_ff + 1'b1;
         end

         bfha_pkg::S_REL_RP: begin
            mem_ra       = rel_idx_ff - 1'b1;
            nf           = ((CW'(rel_idx_ff) + 1'b1) < count_ff) && tbl_rdata.free;
            next_free_in = nf;
            acc_in       = found_size_ff + (nf ? tbl_rdata.size + HDR32 : 32'd0);
         end

         // merge with free neighbors and close the emptied slots
         bfha_pkg::S_REL_MERGE: begin
            pf     = (rel_idx_ff != '0) && tbl_rdata.free;
            mem_we = 1'b1;
            if (pf) begin
               mem_wa = rel_idx_ff - 1'b1;
               mem_wd = '{offset: tbl_rdata.offset,
                          size:   tbl_rdata.size + acc_ff + HDR32,
                          free:   1'b1};
               p      = CW'(rel_idx_ff);
               k      = next_free_ff ? 2'd2 : 2'd1;
            end else begin
               mem_wa = rel_idx_ff;
               mem_wd = '{offset: found_off_ff, size: acc_ff, free: 1'b1};
               p      = CW'(rel_idx_ff) + 1'b1;
               k      = next_free_ff ? 2'd1 : 2'd0;
            end
            mv_up_in    = 1'b0;
            mv_split_in = 1'b0;
            mv_pend_in  = 1'b0;
            mv_k_in     = k;
            mv_rd_in    = p + CW'(k);
            mv_left_in  = (k == 2'd0) ? '0 : count_ff - p - CW'(k);
            count_in    = count_ff - CW'(k);
         end

         bfha_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_copy_ff, res_status_ff, res_addr_ff};
            end
         end

         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfha_pkg::S_IDLE;
         count_ff     <= '0;
         heap_end_ff  <= 32'd0;
         limit_ff     <= bfha_pkg::HEAP_LIMIT_RESET;
         slack_ff     <= bfha_pkg::SPLIT_SLACK_RESET;
         sc_pend_ff   <= 1'b0;
         mv_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         heap_end_ff  <= heap_end_in;
         limit_ff     <= limit_in;
         slack_ff     <= slack_in;
         sc_pend_ff   <= sc_pend_in;
         mv_pend_ff   <= mv_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      sc_rd_ff      <= sc_rd_in;
      sc_tag_ff     <= sc_tag_in;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      found_off_ff  <= found_off_in;
      found_size_ff <= found_size_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      best_off_ff   <= best_off_in;
      best_size_ff  <= best_size_in;
      rel_idx_ff    <= rel_idx_in;
      next_free_ff  <= next_free_in;
      acc_ff        <= acc_in;
      mv_rd_ff      <= mv_rd_in;
      mv_left_ff    <= mv_left_in;
      mv_up_ff      <= mv_up_in;
      mv_k_ff       <= mv_k_in;
      mv_tag_ff     <= mv_tag_in;
      mv_split_ff   <= mv_split_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      res_copy_ff   <= res_copy_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_tready = (state_ff == bfha_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff};

   // checks
   `BFHA_ASSERT_HOLDS(a_count_range, clock, reset, count_ff <= CMAX, "entry count past table depth")
   `BFHA_ASSERT_IMPLIES(a_write_busy, clock, reset, mem_we, state_ff != bfha_pkg::S_IDLE && state_ff != bfha_pkg::S_SCAN, "table written while idle or scanning")
   `BFHA_ASSERT_NEXT(a_accept_scan, clock, reset, req_tvalid && req_tready, state_ff == bfha_pkg::S_SCAN && sc_rd_ff == '0, "accepted item did not start a scan")

endmodule

### hdl/bfha_table.sv
// Block table memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
module bfha_table #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  bfha_pkg::entry_type wr_data,
   input  logic [AW-1:0]       rd_addr,
   output bfha_pkg::entry_type rd_data
);

   bfha_pkg::entry_type mem [DEPTH];
   bfha_pkg::entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### dv/tb_best_fit_heap_allocator.sv
// Self-checking testbench of the best-fit heap allocator, checked against a table predictor.
`timescale 1ns / 1ps
module tb_best_fit_heap_allocator;

   localparam int NBLK = 64;
   localparam int HDR  = 32;
   // op code outside the defined set
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // how the driver fills in addr_in when an item is loaded
   typedef enum logic [1:0] {PICK_LITERAL, PICK_LIVE, PICK_INTERIOR, PICK_FREED} pick_type;

   typedef struct {
      logic [1:0]  op;
      logic [31:0] size;
      logic [31:0] addr;
      pick_type    pick;
   } heap_req_type;

   typedef struct {
      logic [31:0] addr;
      logic [2:0]  status;
      logic [31:0] copy;
   } heap_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // request_size[31:0], addr_in[63:32]
   logic [1:0]  req_tuser = '0;   // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // addr_out[31:0], status[34:32], copy_bytes[66:35]
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [31:0] csr_wdata = '0;

   heap_req_type pending_reqs[$];
   heap_rsp_type expected_rsps[$];
   int errors = 0;
   int accepted_cnt = 0;
   int send_idle_pct = 10;
   int recv_idle_pct = 87;

   // shadow of the block table and registers
   logic [31:0] tbl_ofs[NBLK];
   logic [31:0] tbl_size[NBLK];
   bit          tbl_free[NBLK];
   int          tbl_cnt = 0;
   logic [31:0] heap_end = '0;
   logic [31:0] heap_limit = bfha_pkg::HEAP_LIMIT_RESET;
   logic [31:0] split_slack = {16'd0, bfha_pkg::SPLIT_SLACK_RESET};
   logic [31:0] last_freed = '0;

   best_fit_heap_allocator DUT (.*);

   always #2 clock = ~clock;

   // ---------------- predictor ----------------
   task automatic open_slot(input int pos);
      for (int k = tbl_cnt; k > pos; k--) begin
         tbl_ofs[k] = tbl_ofs[k-1];
         tbl_size[k] = tbl_size[k-1];
         tbl_free[k] = tbl_free[k-1];
      end
      tbl_cnt++;
   endtask

   task automatic close_slot(input int pos);
      for (int k = pos; k < tbl_cnt - 1; k++) begin
         tbl_ofs[k] = tbl_ofs[k+1];
         tbl_size[k] = tbl_size[k+1];
         tbl_free[k] = tbl_free[k+1];
      end
      tbl_cnt--;
   endtask

   function automatic int find_block(input logic [31:0] addr);
      for (int k = 0; k < tbl_cnt; k++)
         if (!tbl_free[k] && ({32'd0, tbl_ofs[k]} + HDR) == {32'd0, addr}) return k;
      return tbl_cnt;
   endfunction

   task automatic heap_alloc(input logic [31:0] size, output logic [31:0] addr,
                             output logic [2:0] status);
      int best;
      logic [63:0] best_size;
      logic [63:0] need;
      best = tbl_cnt;
      best_size = '1;
      addr = '0;
      status = bfha_pkg::ST_OK;
      if (size == 0) begin
         status = bfha_pkg::ST_REJECT;
         return;
      end
      // best fit; an exact size stops the scan
      for (int k = 0; k < tbl_cnt; k++) begin
         if (tbl_free[k] && tbl_size[k] >= size && {32'd0, tbl_size[k]} < best_size) begin
            best = k;
            best_size = tbl_size[k];
            if (tbl_size[k] == size) break;
         end
      end
      if (best < tbl_cnt) begin
         tbl_free[best] = 1'b0;
         if ({32'd0, tbl_size[best]} > {32'd0, size} + HDR + split_slack &&
             tbl_cnt < NBLK) begin
            open_slot(best + 1);
            tbl_ofs[best+1] = tbl_ofs[best] + HDR + size;
            tbl_size[best+1] = tbl_size[best] - size - HDR;
            tbl_free[best+1] = 1'b1;
            tbl_size[best] = size;
         end
         addr = tbl_ofs[best] + HDR;
         return;
      end
      if (tbl_cnt >= NBLK) begin
         status = bfha_pkg::ST_FULL;
         return;
      end
      need = {32'd0, heap_end} + HDR + size;
      if (need > {32'd0, heap_limit}) begin
         status = bfha_pkg::ST_EXHAUSTED;
         return;
      end
      tbl_ofs[tbl_cnt] = heap_end;
      tbl_size[tbl_cnt] = size;
      tbl_free[tbl_cnt] = 1'b0;
      tbl_cnt++;
      heap_end = need[31:0];
      addr = heap_end - size;
   endtask

   task automatic heap_release(input int idx);
      tbl_free[idx] = 1'b1;
      last_freed = tbl_ofs[idx] + HDR;
      if (idx + 1 < tbl_cnt && tbl_free[idx+1]) begin
         tbl_size[idx] = tbl_size[idx] + tbl_size[idx+1] + HDR;
         close_slot(idx + 1);
      end
      if (idx > 0 && tbl_free[idx-1]) begin
         tbl_size[idx-1] = tbl_size[idx-1] + tbl_size[idx] + HDR;
         close_slot(idx);
      end
   endtask

   task automatic predict_heap(input heap_req_type r);
      heap_rsp_type e;
      int idx;
      logic [31:0] old_size;
      e = '{addr: '0, status: bfha_pkg::ST_OK, copy: '0};
      case (r.op)
         bfha_pkg::OP_ALLOC: heap_alloc(r.size, e.addr, e.status);
         bfha_pkg::OP_RELEASE: begin
            if (r.addr != 0) begin
               idx = find_block(r.addr);
               if (idx < tbl_cnt) heap_release(idx);
               else e.status = bfha_pkg::ST_UNKNOWN;
            end
         end
         bfha_pkg::OP_RESIZE: begin
            if (r.addr == 0) begin
               e.status = bfha_pkg::ST_REJECT;
            end else begin
               idx = find_block(r.addr);
               if (idx >= tbl_cnt) begin
                  e.status = bfha_pkg::ST_UNKNOWN;
               end else if (tbl_size[idx] > r.size) begin
                  e.addr = r.addr;
               end else begin
                  old_size = tbl_size[idx];
                  heap_alloc(r.size, e.addr, e.status);
                  if (e.status == bfha_pkg::ST_OK) begin
                     idx = find_block(r.addr);
                     if (idx < tbl_cnt) heap_release(idx);
                     e.copy = old_size;
                  end
               end
            end
         end
         default: e.status = bfha_pkg::ST_REJECT;
      endcase
      expected_rsps.push_back(e);
   endtask

   // user address of a random allocated block, 0 when there is none
   function automatic logic [31:0] live_addr();
      int live[$];
      for (int k = 0; k < tbl_cnt; k++) if (!tbl_free[k]) live.push_back(k);
      if (live.size() == 0) return '0;
      return tbl_ofs[live[$urandom_range(live.size() - 1)]] + HDR;
   endfunction

   // ---------------- driver ----------------
   always @(posedge clock) begin
      heap_req_type r;
      logic nxt_valid;
      logic [31:0] a;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         nxt_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            r.op = req_tuser;
            r.size = req_tdata[31:0];
            r.addr = req_tdata[63:32];
            predict_heap(r);
            accepted_cnt++;
            nxt_valid = 1'b0;
         end
         if (!nxt_valid && pending_reqs.size() > 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            r = pending_reqs.pop_front();
            case (r.pick)
               PICK_LIVE: a = live_addr();
               PICK_INTERIOR: begin
                  a = live_addr();
                  if (a != 0) a = a + 32'd4;
               end
               PICK_FREED: a = last_freed;
               default: a = r.addr;
            endcase
            req_tdata <= {a, r.size};
            req_tuser <= r.op;
            nxt_valid = 1'b1;
         end
         req_tvalid <= nxt_valid;
      end
   end

   // ---------------- monitor ----------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got 0x%08h expected 0x%08h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      heap_rsp_type e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected item", rsp_tdata[31:0], '0);
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_tdata[31:0] !== e.addr) report_mismatch("addr_out", rsp_tdata[31:0], e.addr);
               if (rsp_tdata[34:32] !== e.status)
                  report_mismatch("status", rsp_tdata[34:32], e.status);
               if (rsp_tdata[66:35] !== e.copy)
                  report_mismatch("copy_bytes", rsp_tdata[66:35], e.copy);
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // idle pattern follows progress through the run
   always @(posedge clock) begin
      if (accepted_cnt >= 1250) begin
         send_idle_pct <= 0;
         recv_idle_pct <= 0;
      end else if (accepted_cnt >= 620) begin
         send_idle_pct <= 87;
         recv_idle_pct <= 10;
      end
   end

   // ---------------- stimulus ----------------
   task automatic add_req(input logic [1:0] op, input logic [31:0] size,
                          input logic [31:0] addr, input pick_type pick);
      pending_reqs.push_back('{op: op, size: size, addr: addr, pick: pick});
   endtask

   function automatic logic [31:0] rand_size();
      int p;
      p = $urandom_range(99);
      if (p < 70) return $urandom_range(256, 1);
      if (p < 85) return $urandom_range(8192, 257);
      if (p < 90) return '0;
      return $urandom;
   endfunction

   task automatic add_random(input int n);
      int p;
      repeat (n) begin
         p = $urandom_range(99);
         if (p < 45) add_req(bfha_pkg::OP_ALLOC, rand_size(), '0, PICK_LITERAL);
         else if (p < 68) add_req(bfha_pkg::OP_RELEASE, '0, '0, PICK_LIVE);
         else if (p < 70) add_req(bfha_pkg::OP_RELEASE, '0, '0, PICK_INTERIOR);
         else if (p < 72) add_req(bfha_pkg::OP_RELEASE, '0, $urandom, PICK_LITERAL);
         else if (p < 73) add_req(bfha_pkg::OP_RELEASE, '0, '0, PICK_LITERAL);
         else if (p < 91) add_req(bfha_pkg::OP_RESIZE, rand_size(), '0, PICK_LIVE);
         else if (p < 93) add_req(bfha_pkg::OP_RESIZE, rand_size(), '0, PICK_FREED);
         else if (p < 95) add_req(bfha_pkg::OP_RESIZE, rand_size(), $urandom, PICK_LITERAL);
         else if (p < 96) add_req(bfha_pkg::OP_RESIZE, rand_size(), '0, PICK_LITERAL);
         else add_req(OP_UNUSED, $urandom, $urandom, PICK_LITERAL);
      end
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == bfha_pkg::CSR_HEAP_LIMIT) heap_limit = val;
      else split_slack = {16'd0, val[15:0]};
   endtask

   // wait until every item is sent and answered, sampled away from the driving edge
   task automatic drain();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_tvalid);
      repeat (300) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed opening
      add_req(bfha_pkg::OP_ALLOC, '0, '0, PICK_LITERAL);
      add_req(bfha_pkg::OP_ALLOC, 32'd1, '0, PICK_LITERAL);
      add_req(bfha_pkg::OP_ALLOC, 32'hFFFF_FFFF, '0, PICK_LITERAL);
      add_req(bfha_pkg::OP_ALLOC, 32'd500, '0, PICK_LITERAL);
      add_req(bfha_pkg::OP_ALLOC, 32'd100, '0, PICK_LITERAL);
      add_req(bfha_pkg::OP_ALLOC, 32'd40, '0, PICK_LITERAL);
      add_req(bfha_pkg::OP_RELEASE, '0, '0, PICK_LITERAL);
      add_req(bfha_pkg::OP_RELEASE, '0, 32'd36, PICK_LITERAL);
      add_req(bfha_pkg::OP_RELEASE, '0, 32'hFFFF_FFFF, PICK_LITERAL);
      add_req(bfha_pkg::OP_RELEASE, '0, 32'd64, PICK_LITERAL);
      add_req(bfha_pkg::OP_RELEASE, '0, 32'd64, PICK_LITERAL);
      add_req(bfha_pkg::OP_ALLOC, 32'd1, '0, PICK_LITERAL);
      add_req(bfha_pkg::OP_RELEASE, '0, '0, PICK_LIVE);
      add_req(bfha_pkg::OP_RELEASE, '0, '0, PICK_LIVE);
      add_req(bfha_pkg::OP_ALLOC, 32'd100, '0, PICK_LITERAL);
      add_req(bfha_pkg::OP_ALLOC, 32'd8, '0, PICK_LITERAL);
      add_req(bfha_pkg::OP_RESIZE, 32'd1, '0, PICK_LITERAL);
      add_req(bfha_pkg::OP_RESIZE, 32'd1, '0, PICK_LIVE);
      add_req(bfha_pkg::OP_RESIZE, 32'd3000, '0, PICK_LIVE);
      add_req(bfha_pkg::OP_RESIZE, 32'hFFFF_FFFF, '0, PICK_LIVE);
      add_req(bfha_pkg::OP_RESIZE, 32'd10, '0, PICK_FREED);
      add_req(bfha_pkg::OP_RESIZE, 32'd10, '0, PICK_INTERIOR);
      add_req(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PICK_LITERAL);
      add_req(OP_UNUSED, '0, '0, PICK_LITERAL);
      add_random(450);
      drain();

      // nothing may be appended; only free blocks can be reused
      write_csr(bfha_pkg::CSR_HEAP_LIMIT, '0);
      write_csr(bfha_pkg::CSR_SPLIT_SLACK, '0);
      add_random(150);
      drain();

      // whole address space, maximum split slack
      write_csr(bfha_pkg::CSR_HEAP_LIMIT, 32'hFFFF_FFFF);
      write_csr(bfha_pkg::CSR_SPLIT_SLACK, 32'h0000_FFFF);
      add_random(450);
      drain();

      // limit below the current end: appends fail
      write_csr(bfha_pkg::CSR_HEAP_LIMIT, 32'd8192);
      write_csr(bfha_pkg::CSR_SPLIT_SLACK, 32'd16);
      add_random(400);
      drain();

      write_csr(bfha_pkg::CSR_HEAP_LIMIT, 32'hFFFF_FFFF);
      write_csr(bfha_pkg::CSR_SPLIT_SLACK, '0);
      add_random(400);
      drain();

      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
